// ===== rtl/svpt_pkg.sv =====
// shared types and constants for the sv39 page table store, mapper and walker
// no dependencies
package svpt_pkg;

    localparam int TABLE_PAGES = 64;
    localparam int ENTRIES     = 512;
    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int PPN_W       = 44;
    localparam int PTE_W       = 64;
    localparam int CFG_W       = 44;

    typedef enum logic [1:0]
    {
        KIND_LOAD   = 2'd0,
        KIND_MAP    = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_UNMAPPED  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_OUTSIDE   = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        CFG_STORE_BASE = 2'd0,
        CFG_POOL_FIRST = 2'd1,
        CFG_POOL_COUNT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [43:0] root_page;
        logic [38:0] virt_addr;
        logic [55:0] phys_addr;
        logic [9:0]  prot_bits;
        logic [5:0]  load_page;
        logic [8:0]  load_index;
        logic [63:0] load_data;
    } in_t;

    typedef struct packed
    {
        logic [1:0]  status;
        logic [43:0] entry_ppn;
        logic [8:0]  entry_index;
        logic [63:0] entry_value;
    } out_t;

endpackage

// ===== rtl/sv39_page_table_map_and_walk.sv =====
// sv39 page table store with load, map and lookup sequencer
// depends on svpt_pkg and svpt_store
//
// channel   dir  handshake          word
// in        in   in_valid/in_ready   in_t
// out       out  out_valid/out_ready out_t
// cfg       in   cfg_we              cfg_index, cfg_wdata
//
// one item at a time over the single store port; the sequencer returns to idle before it
// takes the next word, and a write into a page still marked zeroed first sweeps that page
// to zero through the store port before the write lands
// reset clears the sequencer, the zeroed flags and the allocator count; no sweep after reset
// a new word is taken while a finished result waits in the output register
module sv39_page_table_map_and_walk
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  svpt_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output svpt_pkg::out_t               out_data,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [svpt_pkg::CFG_W-1:0]   cfg_wdata
);
    import svpt_pkg::*;

    typedef enum logic [9:0]
    {
        S_IDLE   = 10'b0000000001,
        S_START  = 10'b0000000010,
        S_RD     = 10'b0000000100,
        S_EVAL   = 10'b0000001000,
        S_FOLLOW = 10'b0000010000,
        S_WR     = 10'b0000100000,
        S_CLR    = 10'b0001000000,
        S_LRD    = 10'b0010000000,
        S_LEVAL  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    typedef struct packed
    {
        logic             outside;
        logic [PAGE_W-1:0] page;
    } page_loc_t;

    state_t            state_reg, state_next;
    in_t               item_reg;
    logic [PPN_W-1:0]  base_reg;
    logic [5:0]        pool_first_reg;
    logic [6:0]        pool_count_reg;
    logic [6:0]        next_free_reg;
    logic [TABLE_PAGES-1:0] zeroed_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              lvl_reg;
    logic [PTE_W-1:0]  pte_reg;
    logic [PAGE_W-1:0] wpage_reg;
    logic [IDX_W-1:0]  widx_reg;
    logic [PTE_W-1:0]  wdata_reg;
    logic              ret_follow_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    out_t              res_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PTE_W-1:0]  mem_wdata;
    logic [PTE_W-1:0]  mem_rdata;

    logic [IDX_W-1:0]  vpn_up;
    logic [IDX_W-1:0]  vpn_leaf;
    logic [PTE_W-1:0]  pte_rd;
    logic [PTE_W-1:0]  leaf_rd;
    logic [7:0]        new_page;
    logic [PPN_W-1:0]  new_ppn;
    logic [PTE_W-1:0]  new_pte;
    logic [PTE_W-1:0]  leaf_pte;
    page_loc_t         root_loc;
    page_loc_t         next_loc;
    logic              alloc_go;

    function automatic page_loc_t page_of(input logic [PPN_W-1:0] ppn,
                                          input logic [PPN_W-1:0] base);
        page_loc_t        r;
        logic [PPN_W-1:0] d;
        d         = ppn - base;
        r.outside = (ppn < base) || (d >= PPN_W'(TABLE_PAGES));
        r.page    = d[PAGE_W-1:0];
        return r;
    endfunction

    function automatic logic [PPN_W-1:0] ppn_of(input logic [PAGE_W-1:0] page,
                                                input logic [PPN_W-1:0] base);
        return base + PPN_W'(page);
    endfunction

    svpt_store u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign vpn_up   = lvl_reg ? item_reg.virt_addr[38:30] : item_reg.virt_addr[29:21];
    assign vpn_leaf = item_reg.virt_addr[20:12];
    assign pte_rd   = zeroed_reg[page_reg] ? '0 : mem_rdata;
    assign leaf_rd  = pte_rd;
    assign new_page = 8'(pool_first_reg) + 8'(next_free_reg);
    assign new_ppn  = ppn_of(new_page[PAGE_W-1:0], base_reg);
    assign new_pte  = {10'b0, new_ppn, 9'b0, 1'b1};
    assign leaf_pte = {10'b0, item_reg.phys_addr[55:12], item_reg.prot_bits};
    assign root_loc = page_of(item_reg.root_page, base_reg);
    assign next_loc = page_of(pte_reg[53:10], base_reg);
    assign alloc_go = (state_reg == S_EVAL) && (item_reg.kind == KIND_MAP) && !pte_rd[0]
                      && (next_free_reg < pool_count_reg) && (new_page[7:PAGE_W] == '0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = {page_reg, vpn_up};
        mem_wdata = wdata_reg;
        unique case (state_reg)
            S_LRD:
            begin
                mem_addr = {page_reg, vpn_leaf};
            end
            S_WR:
            begin
                mem_addr = {wpage_reg, widx_reg};
                mem_we   = !zeroed_reg[wpage_reg];
            end
            S_CLR:
            begin
                mem_addr  = {wpage_reg, clr_cnt_reg};
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority case (kind_t'(item_reg.kind))
                    KIND_LOAD:   state_next = S_WR;
                    KIND_NONE:   state_next = S_DONE;
                    default:     state_next = root_loc.outside ? S_DONE : S_RD;
                endcase
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (item_reg.kind == KIND_LOOKUP)
                begin
                    state_next = (!pte_rd[0] || (pte_rd[3:1] != 3'b0)) ? S_DONE : S_FOLLOW;
                end
                else if (!pte_rd[0])
                begin
                    state_next = (next_free_reg >= pool_count_reg || new_page[7:PAGE_W] != '0)
                                 ? S_DONE : S_WR;
                end
                else
                begin
                    state_next = S_FOLLOW;
                end
            end
            S_FOLLOW:
            begin
                if (next_loc.outside)
                begin
                    state_next = S_DONE;
                end
                else if (lvl_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = (item_reg.kind == KIND_MAP) ? S_WR : S_LRD;
                end
            end
            S_WR:
            begin
                if (zeroed_reg[wpage_reg])
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = ret_follow_reg ? S_FOLLOW : S_DONE;
                end
            end
            S_CLR:
            begin
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_WR;
                end
            end
            S_LRD:
            begin
                state_next = S_LEVAL;
            end
            S_LEVAL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= '0;
            pool_first_reg <= '0;
            pool_count_reg <= 7'(TABLE_PAGES);
            next_free_reg  <= '0;
            zeroed_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STORE_BASE: base_reg       <= cfg_wdata;
                    CFG_POOL_FIRST: pool_first_reg <= cfg_wdata[5:0];
                    CFG_POOL_COUNT: pool_count_reg <= cfg_wdata[6:0];
                    CFG_UNUSED:     begin end
                endcase
            end
            if (alloc_go)
            begin
                next_free_reg                          <= next_free_reg + 7'd1;
                zeroed_reg[new_page[PAGE_W-1:0]]       <= 1'b1;
            end
            if (state_reg == S_CLR && clr_cnt_reg == IDX_W'(ENTRIES - 1))
            begin
                zeroed_reg[wpage_reg] <= 1'b0;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_data_reg <= res_reg;
        end
        if (state_reg == S_CLR)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
        unique case (state_reg)
            S_START:
            begin
                priority case (kind_t'(item_reg.kind))
                    KIND_LOAD:
                    begin
                        wpage_reg      <= item_reg.load_page;
                        widx_reg       <= item_reg.load_index;
                        wdata_reg      <= item_reg.load_data;
                        ret_follow_reg <= 1'b0;
                        res_reg        <= '{ST_OK, ppn_of(item_reg.load_page, base_reg),
                                            item_reg.load_index, item_reg.load_data};
                    end
                    KIND_NONE:
                    begin
                        res_reg <= '{ST_UNMAPPED, '0, '0, '0};
                    end
                    default:
                    begin
                        page_reg <= root_loc.page;
                        lvl_reg  <= 1'b1;
                        res_reg  <= '{root_loc.outside ? ST_OUTSIDE : ST_OK, '0, '0, '0};
                    end
                endcase
            end
            S_EVAL:
            begin
                pte_reg <= alloc_go ? new_pte : pte_rd;
                if (item_reg.kind == KIND_LOOKUP)
                begin
                    if (!pte_rd[0] || (pte_rd[3:1] != 3'b0))
                    begin
                        res_reg.status <= ST_UNMAPPED;
                    end
                end
                else if (!pte_rd[0])
                begin
                    if (next_free_reg >= pool_count_reg)
                    begin
                        res_reg.status <= ST_EXHAUSTED;
                    end
                    else if (new_page[7:PAGE_W] != '0)
                    begin
                        res_reg.status <= ST_OUTSIDE;
                    end
                    else
                    begin
                        wpage_reg      <= page_reg;
                        widx_reg       <= vpn_up;
                        wdata_reg      <= new_pte;
                        ret_follow_reg <= 1'b1;
                    end
                end
            end
            S_FOLLOW:
            begin
                page_reg <= next_loc.page;
                lvl_reg  <= 1'b0;
                if (next_loc.outside)
                begin
                    res_reg.status <= ST_OUTSIDE;
                end
                else if (!lvl_reg)
                begin
                    res_reg.entry_ppn   <= ppn_of(next_loc.page, base_reg);
                    res_reg.entry_index <= vpn_leaf;
                    res_reg.entry_value <= leaf_pte;
                    wpage_reg           <= next_loc.page;
                    widx_reg            <= vpn_leaf;
                    wdata_reg           <= leaf_pte;
                    ret_follow_reg      <= 1'b0;
                end
            end
            S_WR:
            begin
                clr_cnt_reg <= '0;
            end
            S_LEVAL:
            begin
                res_reg.entry_value <= leaf_rd;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clr_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> zeroed_reg[wpage_reg])
        else $error("sweep running on a page that is not marked zeroed");

    a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && clr_cnt_reg == IDX_W'(ENTRIES - 1))
        |=> (state_reg == S_WR && !zeroed_reg[wpage_reg]))
        else $error("sweep end did not release the page");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_START)
        else $error("accepted word did not start the sequencer");

endmodule

// ===== rtl/svpt_store.sv =====
// single port table store, registered read
// depends on svpt_pkg
module svpt_store
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [svpt_pkg::ADDR_W-1:0] addr,
    input  logic [svpt_pkg::PTE_W-1:0]  wdata,
    output logic [svpt_pkg::PTE_W-1:0]  rdata
);
    import svpt_pkg::*;

    logic [PTE_W-1:0] mem [TABLE_PAGES*ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== dv/sv39_page_table_map_and_walk_test.sv =====
// self-checking testbench for sv39_page_table_map_and_walk: loads, maps, lookups and KIND_NONE
// words predicted by a table store model, checked word by word; depends on svpt_pkg and the rtl
module sv39_page_table_map_and_walk_test;
    import svpt_pkg::*;

    localparam int LIMIT  = 2000000;
    localparam int SETTLE = 700;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    in_t            in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    out_t           out_data;
    logic           cfg_we = 1'b0;
    logic [1:0]     cfg_index = CFG_STORE_BASE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    sv39_page_table_map_and_walk u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // table store copy
    logic [63:0]  pte_mem [0:TABLE_PAGES*ENTRIES-1];
    bit           pte_known [0:TABLE_PAGES*ENTRIES-1];
    bit           page_clear [0:TABLE_PAGES-1];
    int unsigned  alloc_cnt;
    logic [43:0]  base_ppn;
    int unsigned  first_page;
    int unsigned  page_budget;
    int unsigned  alloc_pages [$];

    in_t   word_q [$];
    out_t  result_q [$];
    int    errors = 0;
    int    cycles;
    int    burst_left;
    int    gap_left;
    int    hold_left;
    int    seen_cnt;
    bit    long_hold_done;
    logic [15:0] ready_pat;

    function automatic int page_of(logic [43:0] ppn);
        logic [43:0] d;
        if (ppn < base_ppn)
            return -1;
        d = ppn - base_ppn;
        if (d >= TABLE_PAGES)
            return -1;
        return int'(d);
    endfunction

    function automatic logic [43:0] ppn_of(int p);
        return base_ppn + 44'(p);
    endfunction

    function automatic logic [63:0] read_pte(int p, int idx, bit commit, int a0, int a1,
                                             inout int miss);
        if (!commit && (p == a0 || p == a1))
            return '0;
        if (page_clear[p])
            return '0;
        if (!pte_known[p*ENTRIES+idx] && miss < 0)
            miss = p*ENTRIES + idx;
        return pte_mem[p*ENTRIES+idx];
    endfunction

    function automatic void write_pte(int p, int idx, logic [63:0] v);
        if (page_clear[p])
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                pte_mem[p*ENTRIES+i] = '0;
                pte_known[p*ENTRIES+i] = 1'b1;
            end
            page_clear[p] = 1'b0;
        end
        pte_mem[p*ENTRIES+idx] = v;
        pte_known[p*ENTRIES+idx] = 1'b1;
    endfunction

    // walks one word; without commit it only reports the first unwritten entry it touches
    function automatic void walk_word(in_t w, bit commit, output out_t res, output int miss);
        status_t     st;
        int          p;
        int          np;
        int          a0;
        int          a1;
        int unsigned nf;
        int          vpn [0:2];
        logic [63:0] pte;
        logic [63:0] leaf;
        st = ST_OK;
        res = '0;
        miss = -1;
        a0 = -1;
        a1 = -1;
        nf = alloc_cnt;
        vpn[0] = int'(w.virt_addr[20:12]);
        vpn[1] = int'(w.virt_addr[29:21]);
        vpn[2] = int'(w.virt_addr[38:30]);
        case (kind_t'(w.kind))
            KIND_LOAD:
            begin
                if (commit)
                    write_pte(int'(w.load_page), int'(w.load_index), w.load_data);
                res.entry_ppn = ppn_of(int'(w.load_page));
                res.entry_index = w.load_index;
                res.entry_value = w.load_data;
            end
            KIND_MAP, KIND_LOOKUP:
            begin
                p = page_of(w.root_page);
                if (p < 0)
                    st = ST_OUTSIDE;
                for (int lvl = 2; lvl > 0 && st == ST_OK; lvl--)
                begin
                    pte = read_pte(p, vpn[lvl], commit, a0, a1, miss);
                    if (kind_t'(w.kind) == KIND_LOOKUP)
                    begin
                        if (!pte[0] || pte[3:1] != 3'b000)
                        begin
                            st = ST_UNMAPPED;
                            break;
                        end
                    end
                    else if (!pte[0])
                    begin
                        if (nf >= page_budget)
                        begin
                            st = ST_EXHAUSTED;
                            break;
                        end
                        np = int'(first_page + nf);
                        if (np >= TABLE_PAGES)
                        begin
                            st = ST_OUTSIDE;
                            break;
                        end
                        nf = (nf + 1) & 127;
                        pte = {10'b0, ppn_of(np), 10'b0} | 64'd1;
                        if (commit)
                        begin
                            page_clear[np] = 1'b1;
                            alloc_pages.push_back(np);
                            write_pte(p, vpn[lvl], pte);
                        end
                        else if (a0 < 0)
                            a0 = np;
                        else
                            a1 = np;
                    end
                    p = page_of(pte[53:10]);
                    if (p < 0)
                        st = ST_OUTSIDE;
                end
                if (st == ST_OK)
                begin
                    res.entry_ppn = ppn_of(p);
                    res.entry_index = 9'(vpn[0]);
                    if (kind_t'(w.kind) == KIND_MAP)
                    begin
                        leaf = {10'b0, w.phys_addr[55:12], w.prot_bits};
                        if (commit)
                            write_pte(p, vpn[0], leaf);
                        res.entry_value = leaf;
                    end
                    else
                        res.entry_value = read_pte(p, vpn[0], commit, a0, a1, miss);
                end
                if (commit)
                    alloc_cnt = nf;
            end
            default:
                st = ST_UNMAPPED;
        endcase
        res.status = st;
    endfunction

    // queues a word, first loading any entry it would read before that entry was written
    function automatic void send_word(in_t w);
        out_t res;
        int   miss;
        in_t  fix;
        for (int t = 0; t < 6; t++)
        begin
            walk_word(w, 1'b0, res, miss);
            if (miss < 0)
            begin
                walk_word(w, 1'b1, res, miss);
                word_q.push_back(w);
                result_q.push_back(res);
                return;
            end
            fix = w;
            fix.kind = KIND_LOAD;
            fix.load_page = 6'(miss / ENTRIES);
            fix.load_index = 9'(miss % ENTRIES);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: fix.load_data = {$urandom, $urandom} & ~64'd1;
                6, 7:    fix.load_data = {10'b0, ppn_of($urandom_range(0, 63)), 10'd1};
                default: fix.load_data = {$urandom, $urandom};
            endcase
            walk_word(fix, 1'b1, res, miss);
            word_q.push_back(fix);
            result_q.push_back(res);
        end
    endfunction

    function automatic logic [8:0] pick_vpn();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd2;
            3: return 9'd511;
            default: return 9'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic in_t rand_word();
        in_t          w;
        int           r;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_t)-1:0];
        r = $urandom_range(0, 99);
        w.kind = r < 15 ? KIND_LOAD : r < 55 ? KIND_MAP : r < 96 ? KIND_LOOKUP : KIND_NONE;
        r = $urandom_range(0, 99);
        if (r < 60)
            w.root_page = ppn_of($urandom_range(0, 3));
        else if (r < 80 && alloc_pages.size() > 0)
            w.root_page = ppn_of(alloc_pages[$urandom_range(0, alloc_pages.size()-1)]);
        else if (r < 90)
            w.root_page = base_ppn - 44'd1;
        if ($urandom_range(0, 4) != 0)
            w.virt_addr = {pick_vpn(), pick_vpn(), 9'($urandom_range(0, 7)), w.virt_addr[11:0]};
        if (w.kind == KIND_LOAD && $urandom_range(0, 1) == 0)
            w.load_data = {10'b0, ppn_of($urandom_range(0, 63)), w.load_data[9:1], 1'b1};
        return w;
    endfunction

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_STORE_BASE: base_ppn = v[43:0];
            CFG_POOL_FIRST: first_page = v[5:0];
            CFG_POOL_COUNT: page_budget = v[6:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (word_q.size() > 0 || in_valid || result_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic directed();
        in_t w;
        w = '0;
        w.kind = KIND_LOAD;
        send_word(w);
        w.load_page = 6'd63;
        w.load_index = 9'd511;
        w.load_data = '1;
        send_word(w);
        w = '1;
        w.kind = KIND_NONE;
        send_word(w);
        w.kind = KIND_MAP;
        send_word(w);
        w.kind = KIND_LOOKUP;
        send_word(w);
        w = '0;
        w.kind = KIND_LOAD;
        w.load_page = 6'd1;
        w.load_index = 9'd5;
        send_word(w);
        w.kind = KIND_MAP;
        w.root_page = ppn_of(1);
        w.virt_addr = {9'd5, 9'd7, 9'd9, 12'hfff};
        w.phys_addr = '1;
        w.prot_bits = '1;
        send_word(w);
        w.kind = KIND_LOOKUP;
        send_word(w);
        w.virt_addr = {9'd5, 9'd7, 9'd10, 12'h0};
        send_word(w);
        w.virt_addr = {9'd5, 9'd8, 9'd9, 12'h0};
        send_word(w);
        w.kind = KIND_LOAD;
        w.load_page = 6'd2;
        w.load_index = 9'd3;
        w.load_data = {10'b0, ppn_of(3), 10'b0000001111};
        send_word(w);
        w.kind = KIND_LOOKUP;
        w.root_page = ppn_of(2);
        w.virt_addr = {9'd3, 9'd0, 9'd0, 12'h0};
        send_word(w);
        w.kind = KIND_MAP;
        w.phys_addr = 56'h123456789ab000;
        w.prot_bits = 10'h0cf;
        send_word(w);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        alloc_cnt = 0;
        base_ppn = '0;
        first_page = 0;
        page_budget = 64;
        for (int i = 0; i < TABLE_PAGES*ENTRIES; i++)
        begin
            pte_mem[i] = '0;
            pte_known[i] = 1'b0;
        end
        for (int i = 0; i < TABLE_PAGES; i++)
            page_clear[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    cfg_write(CFG_STORE_BASE, 44'd0);
                    cfg_write(CFG_POOL_FIRST, 44'd0);
                    cfg_write(CFG_POOL_COUNT, 44'd64);
                end
                1:
                begin
                    cfg_write(CFG_STORE_BASE, {12'($urandom_range(1, 4095)), $urandom});
                    cfg_write(CFG_POOL_FIRST, 44'd8);
                    cfg_write(CFG_POOL_COUNT, 44'd24);
                end
                2:
                begin
                    cfg_write(CFG_STORE_BASE, 44'hfff_ffff_ffff);
                    cfg_write(CFG_POOL_FIRST, 44'd63);
                    cfg_write(CFG_POOL_COUNT, 44'd0);
                end
                default:
                begin
                    cfg_write(CFG_STORE_BASE, 44'd1000);
                    cfg_write(CFG_POOL_FIRST, 44'd40);
                    cfg_write(CFG_POOL_COUNT, 44'd64);
                end
            endcase
            if (ph == 0)
                directed();
            for (int n = 0; n < 500; n++)
                send_word(rand_word());
            drain();
        end
        if (errors == 0 && result_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (word_q.size() > 0)
            begin
                in_data <= word_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
            ready_pat <= 16'hffff;
        end
        else
        begin
            if (cycles % 256 == 0)
                ready_pat <= $urandom_range(0, 2) == 0 ? 16'hffff : 16'($urandom);
            else
                ready_pat <= {ready_pat[14:0], ready_pat[15]};
            if (!long_hold_done && seen_cnt == 700)
            begin
                long_hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ready_pat[0];
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
            seen_cnt <= 0;
        else if (out_valid && out_ready)
        begin
            seen_cnt <= seen_cnt + 1;
            if (result_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %h", out_data);
            end
            else
            begin
                want = result_q.pop_front();
                if (out_data.status !== want.status || out_data.entry_ppn !== want.entry_ppn
                    || out_data.entry_index !== want.entry_index
                    || out_data.entry_value !== want.entry_value)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("word %0d: expected st %0d ppn %h idx %h val %h",
                                 seen_cnt, want.status, want.entry_ppn, want.entry_index,
                                 want.entry_value);
                        $display("word %0d: got      st %0d ppn %h idx %h val %h",
                                 seen_cnt, out_data.status, out_data.entry_ppn,
                                 out_data.entry_index, out_data.entry_value);
                    end
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
